// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/eiec_pkg.sv
// ---------------------------------------------------------------------------
// eiec_pkg
// Types and constants of the external interrupt edge controller.
// ---------------------------------------------------------------------------
package eiec_pkg;

    localparam int NUM_LINES   = 16;
    localparam int NUM_PORTS   = 4;
    localparam int SEL_W       = 4;
    localparam int NUM_VECTORS = 7;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    typedef logic [NUM_LINES-1:0]   line_vec_t;
    typedef logic [NUM_VECTORS-1:0] vector_t;
    typedef logic [SEL_W-1:0]       sel_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam cfg_idx_t REG_RISING_EN  = 3'd0;
    localparam cfg_idx_t REG_FALLING_EN = 3'd1;
    localparam cfg_idx_t REG_UNMASK     = 3'd2;
    localparam cfg_idx_t REG_ROUTING    = 3'd3;
    localparam cfg_idx_t REG_VECTOR_EN  = 3'd4;

    typedef struct packed {
        logic [NUM_PORTS-1:0] pins;
        sel_t                 sel;
        logic                 rise_en;
        logic                 fall_en;
        logic                 prev_level;
        logic                 pending;
        logic                 clear;
        logic                 sample;
    } lane_in_t;

    typedef struct packed {
        logic level;
        logic pending_next;
    } lane_out_t;

endpackage

// File: src/eiec_item_if.sv
// ---------------------------------------------------------------------------
// eiec_item_if
// Input item channel: command, four port level words and clear bits.
// ---------------------------------------------------------------------------
interface eiec_item_if;

    logic                valid;
    logic                ready;
    logic                command;
    eiec_pkg::line_vec_t port_a_levels;
    eiec_pkg::line_vec_t port_b_levels;
    eiec_pkg::line_vec_t port_c_levels;
    eiec_pkg::line_vec_t port_d_levels;
    eiec_pkg::line_vec_t clear_bits;

    modport source (
        output valid, command, port_a_levels, port_b_levels, port_c_levels,
               port_d_levels, clear_bits,
        input  ready
    );

    modport sink (
        input  valid, command, port_a_levels, port_b_levels, port_c_levels,
               port_d_levels, clear_bits,
        output ready
    );

endinterface

// File: src/eiec_result_if.sv
// ---------------------------------------------------------------------------
// eiec_result_if
// Result item channel: pending lines, vector requests and routed levels.
// ---------------------------------------------------------------------------
interface eiec_result_if;

    logic                valid;
    logic                ready;
    eiec_pkg::line_vec_t pending_lines;
    eiec_pkg::vector_t   vector_requests;
    eiec_pkg::line_vec_t routed_levels;

    modport source (
        output valid, pending_lines, vector_requests, routed_levels,
        input  ready
    );

    modport sink (
        input  valid, pending_lines, vector_requests, routed_levels,
        output ready
    );

endinterface

// File: src/external_interrupt_edge_controller.sv
// ---------------------------------------------------------------------------
// external_interrupt_edge_controller
// Sixteen-line external interrupt controller with port routing, edge
// detection, write-one-to-clear pending bits and grouped vector requests.
//
//   channel      | dir | handshake         | contents
//   -------------+-----+-------------------+---------------------------------
//   item_in      | in  | valid/ready       | command, port A-D levels, clear
//   result_out   | out | valid/ready       | pending, vectors, routed levels
//   cfg          | in  | cfg_we, no ready  | register index and data
//
// One item per cycle while the result side takes results; the result appears in the cycle after acceptance.
// All lanes evaluate in parallel in the accepting cycle; a single output
// register parts the two channels.
// Reset clears configuration, previous levels, pending bits and output valid.
// A stalled result holds; item_in stays ready while the output register
// drains in the same cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module external_interrupt_edge_controller #(
    parameter int LINE_COUNT = 16,
    parameter int PORT_COUNT = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    eiec_item_if.sink                              item_in,
    eiec_result_if.source                          result_out,
    input  logic                                   cfg_we,
    input  eiec_pkg::cfg_idx_t                     cfg_index,
    input  logic [eiec_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam eiec_pkg::line_vec_t LINE_MASK =
        eiec_pkg::line_vec_t'((33'h1 << LINE_COUNT) - 33'h1);

    eiec_pkg::line_vec_t                   rising_en_reg;
    eiec_pkg::line_vec_t                   falling_en_reg;
    eiec_pkg::line_vec_t                   unmask_reg;
    logic [eiec_pkg::CFG_DATA_W-1:0]       routing_reg;
    eiec_pkg::vector_t                     vector_en_reg;

    eiec_pkg::line_vec_t                   prev_reg;
    eiec_pkg::line_vec_t                   prev_next;
    eiec_pkg::line_vec_t                   pending_reg;
    eiec_pkg::line_vec_t                   pending_next;

    logic                                  out_valid_reg;
    eiec_pkg::line_vec_t                   out_pending_reg;
    eiec_pkg::vector_t                     out_vector_reg;
    eiec_pkg::line_vec_t                   out_levels_reg;

    eiec_pkg::line_vec_t                   levels;
    eiec_pkg::vector_t                     vectors;
    logic                                  accept;
    logic                                  sample;

    assign item_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = item_in.valid && item_in.ready;
    assign sample        = (item_in.command == eiec_pkg::CMD_SAMPLE);

    for (genvar i = 0; i < eiec_pkg::NUM_LINES; i++)
    begin : g_lane
        if (i < LINE_COUNT)
        begin : g_used
            eiec_pkg::lane_in_t  lane_in;
            eiec_pkg::lane_out_t lane_out;

            always_comb
            begin
                lane_in.pins       = {item_in.port_d_levels[i], item_in.port_c_levels[i],
                                      item_in.port_b_levels[i], item_in.port_a_levels[i]};
                lane_in.sel        = routing_reg[eiec_pkg::SEL_W*i +: eiec_pkg::SEL_W];
                lane_in.rise_en    = rising_en_reg[i];
                lane_in.fall_en    = falling_en_reg[i];
                lane_in.prev_level = prev_reg[i];
                lane_in.pending    = pending_reg[i];
                lane_in.clear      = item_in.clear_bits[i];
                lane_in.sample     = sample;
            end

            eiec_lane #(
                .PORT_COUNT (PORT_COUNT)
            ) u_lane (
                .lane_in  (lane_in),
                .lane_out (lane_out)
            );

            assign levels[i]       = lane_out.level;
            assign pending_next[i] = lane_out.pending_next;
        end
        else
        begin : g_unused
            assign levels[i]       = 1'b0;
            assign pending_next[i] = 1'b0;
        end
    end

    assign prev_next = sample ? levels : prev_reg;

    eiec_merge u_merge (
        .pending   (pending_next),
        .unmask    (unmask_reg),
        .vector_en (vector_en_reg),
        .vectors   (vectors)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rising_en_reg  <= '0;
            falling_en_reg <= '0;
            unmask_reg     <= '0;
            routing_reg    <= '0;
            vector_en_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eiec_pkg::REG_RISING_EN:  rising_en_reg  <= cfg_data[eiec_pkg::NUM_LINES-1:0];
                eiec_pkg::REG_FALLING_EN: falling_en_reg <= cfg_data[eiec_pkg::NUM_LINES-1:0];
                eiec_pkg::REG_UNMASK:     unmask_reg     <= cfg_data[eiec_pkg::NUM_LINES-1:0];
                eiec_pkg::REG_ROUTING:    routing_reg    <= cfg_data;
                eiec_pkg::REG_VECTOR_EN:  vector_en_reg  <= cfg_data[eiec_pkg::NUM_VECTORS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_reg    <= prev_next;
                pending_reg <= pending_next;
            end
            if (item_in.ready)
            begin
                out_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_pending_reg <= pending_next;
            out_vector_reg  <= vectors;
            out_levels_reg  <= levels;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.pending_lines   = out_pending_reg;
    assign result_out.vector_requests = out_vector_reg;
    assign result_out.routed_levels   = out_levels_reg;

    `ASSERT_IMPL(a_no_pending_beyond_lines, 1'b1,
                 (pending_reg & ~LINE_MASK) == '0,
                 "pending bit set on a line beyond LINE_COUNT")
    `ASSERT_NEXT(a_clear_sets_nothing,
                 accept && item_in.command == eiec_pkg::CMD_CLEAR,
                 (pending_reg & ~$past(pending_reg)) == '0,
                 "clear item set a pending bit")
    `ASSERT_NEXT(a_clear_keeps_levels,
                 accept && item_in.command == eiec_pkg::CMD_CLEAR,
                 $stable(prev_reg),
                 "clear item changed previous levels")
    `ASSERT_IMPL(a_vector_needs_pending,
                 out_valid_reg && out_vector_reg != '0,
                 out_pending_reg != '0,
                 "vector request without a pending line")

endmodule

// File: src/eiec_lane.sv
// ---------------------------------------------------------------------------
// eiec_lane
// One interrupt line: port selection, edge detection and pending update.
// ---------------------------------------------------------------------------
module eiec_lane #(
    parameter int PORT_COUNT = 4
) (
    input  eiec_pkg::lane_in_t  lane_in,
    output eiec_pkg::lane_out_t lane_out
);

    localparam int PORT_LIMIT =
        (PORT_COUNT < eiec_pkg::NUM_PORTS) ? PORT_COUNT : eiec_pkg::NUM_PORTS;

    logic [1:0] port_sel;
    logic       level;
    logic       rise;
    logic       fall;

    always_comb
    begin
        if (lane_in.sel < eiec_pkg::SEL_W'(PORT_LIMIT))
        begin
            port_sel = lane_in.sel[1:0];
        end
        else
        begin
            port_sel = 2'd0;
        end
    end

    assign level = lane_in.pins[port_sel];
    assign rise  = level & ~lane_in.prev_level & lane_in.rise_en;
    assign fall  = ~level & lane_in.prev_level & lane_in.fall_en;

    always_comb
    begin
        lane_out.level = level;
        if (lane_in.sample)
        begin
            lane_out.pending_next = lane_in.pending | rise | fall;
        end
        else
        begin
            lane_out.pending_next = lane_in.pending & ~lane_in.clear;
        end
    end

endmodule

// File: src/eiec_merge.sv
// ---------------------------------------------------------------------------
// eiec_merge
// Combine unmasked pending lines into the seven interrupt vectors.
// ---------------------------------------------------------------------------
module eiec_merge (
    input  eiec_pkg::line_vec_t pending,
    input  eiec_pkg::line_vec_t unmask,
    input  eiec_pkg::vector_t   vector_en,
    output eiec_pkg::vector_t   vectors
);

    eiec_pkg::line_vec_t active;
    eiec_pkg::vector_t   raw;

    assign active = pending & unmask;

    always_comb
    begin
        raw[4:0] = active[4:0];
        raw[5]   = |active[9:5];
        raw[6]   = |active[15:10];
    end

    assign vectors = raw & vector_en;

endmodule

// File: test/eiec_line_checker.sv
// ---------------------------------------------------------------------------
// eiec_line_checker
// Watches the item, result and configuration ports of the external
// interrupt edge controller. It keeps its own copy of the registers, the
// previous routed levels and the pending bits, predicts the result of every
// accepted item and compares it field by field with the result taken.
// ---------------------------------------------------------------------------
module eiec_line_checker
    import eiec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    eiec_item_if                  item_mon,
    eiec_result_if                result_mon,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    sample_count,
    output int                    clear_count,
    output int                    request_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        line_vec_t pending;
        vector_t   vectors;
        line_vec_t levels;
    } line_outcome_t;

    line_outcome_t          awaited_results[$];
    line_vec_t              rise_en;
    line_vec_t              fall_en;
    line_vec_t              unmask;
    logic [CFG_DATA_W-1:0]  routing;
    vector_t                vector_en;
    line_vec_t              last_levels;
    line_vec_t              pending;
    int                     result_index;

    function automatic line_vec_t route_pins(line_vec_t a, line_vec_t b, line_vec_t c,
                                            line_vec_t d);
        line_vec_t levels;
        sel_t      sel;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            sel = routing[SEL_W*i +: SEL_W];
            if (sel > 4'd3 || int'(sel) >= NUM_PORTS)
                sel = '0;
            case (sel)
                4'd1:    levels[i] = b[i];
                4'd2:    levels[i] = c[i];
                4'd3:    levels[i] = d[i];
                default: levels[i] = a[i];
            endcase
        end
        return levels;
    endfunction

    function automatic vector_t group_vectors(line_vec_t active);
        vector_t v;
        v = {|active[15:10], |active[9:5], active[4:0]};
        return v & vector_en;
    endfunction

    function automatic line_outcome_t advance_lines(logic cmd, line_vec_t a, line_vec_t b,
                                                    line_vec_t c, line_vec_t d,
                                                    line_vec_t clr);
        line_outcome_t o;
        line_vec_t     levels;
        levels = route_pins(a, b, c, d);
        if (cmd == CMD_SAMPLE)
        begin
            pending     = pending | (levels & ~last_levels & rise_en)
                                  | (~levels & last_levels & fall_en);
            last_levels = levels;
        end
        else
        begin
            pending = pending & ~clr;
        end
        o.pending = pending;
        o.vectors = group_vectors(pending & unmask);
        o.levels  = levels;
        return o;
    endfunction

    task automatic report(input string msg);
        fail_count++;
        $display("[%0t] result %0d: %s", $realtime, result_index, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_outcome_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            rise_en       = '0;
            fall_en       = '0;
            unmask        = '0;
            routing       = '0;
            vector_en     = '0;
            last_levels   = '0;
            pending       = '0;
            result_index  = 0;
            fail_count    = 0;
            outstanding   = 0;
            sample_count  = 0;
            clear_count   = 0;
            request_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RISING_EN:  rise_en   = cfg_data[NUM_LINES-1:0];
                    REG_FALLING_EN: fall_en   = cfg_data[NUM_LINES-1:0];
                    REG_UNMASK:     unmask    = cfg_data[NUM_LINES-1:0];
                    REG_ROUTING:    routing   = cfg_data;
                    REG_VECTOR_EN:  vector_en = cfg_data[NUM_VECTORS-1:0];
                    default:        ;
                endcase
            end
            if (result_mon.valid && result_mon.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report("result with no item outstanding");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_mon.pending_lines !== want.pending)
                        report($sformatf("pending_lines %h, expected %h",
                                         result_mon.pending_lines, want.pending));
                    if (result_mon.vector_requests !== want.vectors)
                        report($sformatf("vector_requests %h, expected %h",
                                         result_mon.vector_requests, want.vectors));
                    if (result_mon.routed_levels !== want.levels)
                        report($sformatf("routed_levels %h, expected %h",
                                         result_mon.routed_levels, want.levels));
                    if (want.vectors != '0)
                        request_count++;
                end
                result_index++;
            end
            if (item_mon.valid && item_mon.ready)
            begin
                awaited_results.push_back(advance_lines(item_mon.command,
                    item_mon.port_a_levels, item_mon.port_b_levels,
                    item_mon.port_c_levels, item_mon.port_d_levels,
                    item_mon.clear_bits));
                if (item_mon.command == CMD_SAMPLE)
                    sample_count++;
                else
                    clear_count++;
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// File: test/tb_external_interrupt_edge_controller.sv
// ---------------------------------------------------------------------------
// tb_external_interrupt_edge_controller
// Drives the external interrupt edge controller with a directed set of
// edge, clear, routing and vector cases, then with phases of random items
// under random register settings, with random gaps on the item side and
// random stalls on the result side. The line checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_external_interrupt_edge_controller;
    import eiec_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 120;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    sample_count;
    int                    clear_count;
    int                    request_count;
    int                    cycle_count;
    int                    write_count;
    bit                    calm;
    line_vec_t             pins_a;
    line_vec_t             pins_b;
    line_vec_t             pins_c;
    line_vec_t             pins_d;

    eiec_item_if   item_ch ();
    eiec_result_if result_ch ();

    external_interrupt_edge_controller dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    eiec_line_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_mon      (item_ch),
        .result_mon    (result_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .sample_count  (sample_count),
        .clear_count   (clear_count),
        .request_count (request_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        write_count++;
    endtask

    task automatic send_item(input logic cmd, input line_vec_t a, input line_vec_t b,
                             input line_vec_t c, input line_vec_t d, input line_vec_t clr);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.command       <= cmd;
        item_ch.port_a_levels <= a;
        item_ch.port_b_levels <= b;
        item_ch.port_c_levels <= c;
        item_ch.port_d_levels <= d;
        item_ch.clear_bits    <= clr;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // drop valid and wait for every result to drain
    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic line_vec_t pick_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return line_vec_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_routing();
        logic [CFG_DATA_W-1:0] r;
        case ($urandom_range(0, 4))
            0: r = '0;
            1: r = '1;
            2: r = {$urandom, $urandom};
            default:
                for (int i = 0; i < NUM_LINES; i++)
                    r[SEL_W*i +: SEL_W] = sel_t'($urandom_range(0, 3));
        endcase
        return r;
    endfunction

    function automatic vector_t pick_vectors();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return vector_t'($urandom);
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_RISING_EN, CFG_DATA_W'(pick_mask()));
        write_reg(REG_FALLING_EN, CFG_DATA_W'(pick_mask()));
        write_reg(REG_UNMASK, CFG_DATA_W'(pick_mask()));
        write_reg(REG_ROUTING, pick_routing());
        write_reg(REG_VECTOR_EN, CFG_DATA_W'(pick_vectors()));
        if ($urandom_range(0, 1) == 0)
            write_reg(cfg_idx_t'($urandom_range(5, 7)), {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        logic      cmd;
        line_vec_t clr;
        cmd = ($urandom_range(0, 4) == 0) ? CMD_CLEAR : CMD_SAMPLE;
        if ($urandom_range(0, 9) < 7)
        begin
            pins_a ^= line_vec_t'($urandom & $urandom & $urandom);
            pins_b ^= line_vec_t'($urandom & $urandom & $urandom);
            pins_c ^= line_vec_t'($urandom & $urandom & $urandom);
            pins_d ^= line_vec_t'($urandom & $urandom & $urandom);
        end
        else
        begin
            pins_a = line_vec_t'($urandom);
            pins_b = line_vec_t'($urandom);
            pins_c = line_vec_t'($urandom);
            pins_d = line_vec_t'($urandom);
        end
        clr = ($urandom_range(0, 3) == 0) ? line_vec_t'('1) : line_vec_t'($urandom);
        send_item(cmd, pins_a, pins_b, pins_c, pins_d, clr);
    endtask

    // result side: stall for a drawn number of cycles before each item
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_RISING_EN;
        cfg_data              <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.command       <= CMD_SAMPLE;
        item_ch.port_a_levels <= '0;
        item_ch.port_b_levels <= '0;
        item_ch.port_c_levels <= '0;
        item_ch.port_d_levels <= '0;
        item_ch.clear_bits    <= '0;
        calm        = 1'b0;
        cycle_count = 0;
        write_count = 0;
        pins_a = '0;
        pins_b = '0;
        pins_c = '0;
        pins_d = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every edge enabled, all lines on port A
        write_reg(REG_RISING_EN, 64'hFFFF);
        write_reg(REG_FALLING_EN, 64'hFFFF);
        write_reg(REG_UNMASK, 64'hFFFF);
        write_reg(REG_ROUTING, '0);
        write_reg(REG_VECTOR_EN, 64'h7F);
        cfg_we <= 1'b0;
        send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(CMD_CLEAR,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001F);
        send_item(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h03E0);
        send_item(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFC00);
        // clear step shows levels but leaves the previous levels alone
        send_item(CMD_CLEAR,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();

        // selectors 0..15 across the lines, out-of-range ones fall back to A
        write_reg(REG_ROUTING, 64'hFEDC_BA98_7654_3210);
        write_reg(REG_RISING_EN, 64'h00FF);
        write_reg(REG_FALLING_EN, 64'hFF00);
        write_reg(REG_UNMASK, 64'h5555);
        write_reg(cfg_idx_t'(5), '1);
        write_reg(cfg_idx_t'(6), '1);
        write_reg(cfg_idx_t'(7), '1);
        cfg_we <= 1'b0;
        send_item(CMD_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 16'h0000);
        drain();

        // all-ones selectors, vectors disabled, rising only
        write_reg(REG_ROUTING, '1);
        write_reg(REG_VECTOR_EN, '0);
        write_reg(REG_UNMASK, 64'hFFFF);
        write_reg(REG_RISING_EN, 64'hFFFF);
        write_reg(REG_FALLING_EN, '0);
        cfg_we <= 1'b0;
        send_item(CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();

        // all lines on port D, falling only
        write_reg(REG_ROUTING, 64'h3333_3333_3333_3333);
        write_reg(REG_VECTOR_EN, 64'h7F);
        write_reg(REG_RISING_EN, '0);
        write_reg(REG_FALLING_EN, 64'hFFFF);
        cfg_we <= 1'b0;
        send_item(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(CMD_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 16'h8001, 16'h0000);
        drain();

        // all lines on port C
        write_reg(REG_ROUTING, 64'h2222_2222_2222_2222);
        write_reg(REG_RISING_EN, 64'hFFFF);
        cfg_we <= 1'b0;
        send_item(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            random_config();
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            drain();
        end

        calm = 1'b0;
        repeat (4) @(posedge clk);
        $display("covered %0d sample and %0d clear items, %0d results with requests",
                 sample_count, clear_count, request_count);
        $display("%0d register writes across %0d random phases", write_count, PHASES);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
